>>> design/rucfh_pkg.sv
// ----------------------------------------------------------------------------
// rucfh_pkg
// Shared widths, types and the triangle corner table of the cube face hit test.
// ----------------------------------------------------------------------------
package rucfh_pkg;

	localparam int CW            = 32;
	localparam int FRAC_BITS_DEF = 16;
	localparam int TVW           = 34;
	localparam int PW            = 34;
	localparam int QW            = 35;
	localparam int DETW          = 36;
	localparam int TNW           = 37;
	localparam int MOPW          = 36;
	localparam int MHW           = 18;
	localparam int ACCW          = 72;
	localparam int NFACE         = 12;
	localparam int FW            = 4;
	localparam int SIDEW         = 3;
	localparam int STEPW         = 4;
	localparam int IN_BYTES      = 36;
	localparam int OUT_BYTES     = 1;

	localparam logic [FW-1:0]    LAST_FACE = FW'(NFACE - 1);
	localparam logic [STEPW-1:0] STEP_U    = STEPW'(7);
	localparam logic [STEPW-1:0] STEP_V0   = STEPW'(6);
	localparam logic [STEPW-1:0] STEP_END  = STEPW'(13);
	localparam logic [STEPW-1:0] STEP_MULS = STEPW'(12);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SETUP,
		ST_MUL,
		ST_FIX,
		ST_TEST,
		ST_DIV,
		ST_RANK,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic en;
		logic clr;
		logic hi;
	} mac_ctl_t;

	typedef struct packed {
		logic [2:0][TVW-1:0] tv;
		logic [2:0][PW-1:0]  p;
		logic [2:0][QW-1:0]  q;
		logic signed [DETW-1:0] det;
		logic signed [TNW-1:0]  tnum;
	} geom_t;

	// corner codes {c0, c1, c2}: bit 2 x, bit 1 y, bit 0 z
	function automatic logic [8:0] tri_corners(input logic [FW-1:0] f);
		logic [8:0] r;
		case (f)
			4'd0:    r = {3'd7, 3'd3, 3'd1};
			4'd1:    r = {3'd1, 3'd5, 3'd7};
			4'd2:    r = {3'd7, 3'd5, 3'd4};
			4'd3:    r = {3'd4, 3'd6, 3'd7};
			4'd4:    r = {3'd7, 3'd6, 3'd2};
			4'd5:    r = {3'd2, 3'd3, 3'd7};
			4'd6:    r = {3'd3, 3'd2, 3'd0};
			4'd7:    r = {3'd0, 3'd1, 3'd3};
			4'd8:    r = {3'd0, 3'd4, 3'd5};
			4'd9:    r = {3'd5, 3'd1, 3'd0};
			4'd10:   r = {3'd4, 3'd0, 3'd2};
			4'd11:   r = {3'd2, 3'd6, 3'd4};
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

>>> design/rucfh_geom.sv
// ----------------------------------------------------------------------------
// rucfh_geom
// Edge vectors, p = d x e2, q = tv x e1, det and t numerator of one triangle.
// ----------------------------------------------------------------------------
module rucfh_geom #(
	parameter int FRAC_BITS = rucfh_pkg::FRAC_BITS_DEF
) (
	input  logic [rucfh_pkg::FW-1:0]         face,
	input  logic [2:0][rucfh_pkg::CW-1:0]    pos,
	input  logic [2:0][rucfh_pkg::CW-1:0]    org,
	input  logic [2:0][rucfh_pkg::CW-1:0]    dir,
	output rucfh_pkg::geom_t                 g
);

	localparam int MW = rucfh_pkg::MOPW;
	localparam logic signed [rucfh_pkg::TVW-1:0] UNIT =
		rucfh_pkg::TVW'(64'sd1 <<< FRAC_BITS);

	function automatic logic signed [MW-1:0] sc(input logic signed [MW-1:0] x,
		input logic signed [1:0] e);
		logic signed [MW-1:0] r;
		if (e == 2'sb01) begin
			r = x;
		end else if (e == 2'sb11) begin
			r = -x;
		end else begin
			r = '0;
		end
		return r;
	endfunction

	logic [8:0] cc;
	logic [2:0] c0, c1, c2;
	logic signed [1:0] e1 [3];
	logic signed [1:0] e2 [3];
	logic signed [rucfh_pkg::TVW-1:0] tv [3];
	logic signed [MW-1:0] dx [3];
	logic signed [MW-1:0] tx [3];
	logic signed [MW-1:0] px [3];
	logic signed [MW-1:0] qx [3];

	always_comb begin
		cc = rucfh_pkg::tri_corners(face);
		c0 = cc[8:6];
		c1 = cc[5:3];
		c2 = cc[2:0];
		for (int k = 0; k < 3; k++) begin
			e1[k] = $signed({1'b0, c2[2-k]}) - $signed({1'b0, c0[2-k]});
			e2[k] = $signed({1'b0, c1[2-k]}) - $signed({1'b0, c0[2-k]});
			tv[k] = rucfh_pkg::TVW'($signed(org[k])) - rucfh_pkg::TVW'($signed(pos[k]))
				- (c0[2-k] ? UNIT : '0);
			dx[k] = MW'($signed(dir[k]));
			tx[k] = MW'(tv[k]);
		end
		px[0] = sc(dx[1], e2[2]) - sc(dx[2], e2[1]);
		px[1] = sc(dx[2], e2[0]) - sc(dx[0], e2[2]);
		px[2] = sc(dx[0], e2[1]) - sc(dx[1], e2[0]);
		qx[0] = sc(tx[1], e1[2]) - sc(tx[2], e1[1]);
		qx[1] = sc(tx[2], e1[0]) - sc(tx[0], e1[2]);
		qx[2] = sc(tx[0], e1[1]) - sc(tx[1], e1[0]);
		for (int k = 0; k < 3; k++) begin
			g.tv[k] = tv[k];
			g.p[k]  = px[k][rucfh_pkg::PW-1:0];
			g.q[k]  = qx[k][rucfh_pkg::QW-1:0];
		end
		g.det = rucfh_pkg::DETW'(sc(px[0], e1[0]) + sc(px[1], e1[1]) + sc(px[2], e1[2]));
		g.tnum = rucfh_pkg::TNW'(sc(qx[0], e2[0])) + rucfh_pkg::TNW'(sc(qx[1], e2[1]))
			+ rucfh_pkg::TNW'(sc(qx[2], e2[2]));
	end

endmodule

>>> design/rucfh_mac.sv
// ----------------------------------------------------------------------------
// rucfh_mac
// Shared multiply-accumulate: one signed product in two half-width passes.
// ----------------------------------------------------------------------------
module rucfh_mac (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  rucfh_pkg::mac_ctl_t                   ctl,
	input  logic signed [rucfh_pkg::MOPW-1:0]     a,
	input  logic signed [rucfh_pkg::MOPW-1:0]     b,
	output logic signed [rucfh_pkg::ACCW-1:0]     acc
);

	localparam int MW  = rucfh_pkg::MOPW;
	localparam int HW  = rucfh_pkg::MHW;
	localparam int PRW = MW + HW + 1;

	logic signed [HW:0]      bpart;
	logic signed [PRW-1:0]   prod;
	logic signed [PRW-1:0]   prod_s1;
	rucfh_pkg::mac_ctl_t     ctl_s1;
	logic signed [rucfh_pkg::ACCW-1:0] acc_q;
	logic signed [rucfh_pkg::ACCW-1:0] addend;

	always_comb begin
		bpart = ctl.hi ? $signed({b[MW-1], b[MW-1:HW]}) : $signed({1'b0, b[HW-1:0]});
		prod  = PRW'(a) * PRW'(bpart);
		addend = ctl_s1.hi ? (rucfh_pkg::ACCW'(prod_s1) <<< HW) : rucfh_pkg::ACCW'(prod_s1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else begin
			ctl_s1 <= ctl;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= prod;
		if (ctl_s1.en) begin
			acc_q <= (ctl_s1.clr ? '0 : acc_q) + addend;
		end
	end

	assign acc = acc_q;

endmodule

>>> design/rucfh_div.sv
// ----------------------------------------------------------------------------
// rucfh_div
// Radix-2 restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rucfh_div #(
	parameter int NW = rucfh_pkg::TNW - 1 + rucfh_pkg::FRAC_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [NW-1:0]                 num,
	input  logic [rucfh_pkg::DETW-1:0]    den,
	output logic                          busy,
	output logic [NW-1:0]                 quo
);

	localparam int DW   = rucfh_pkg::DETW;
	localparam int CNTW = $clog2(NW + 1);

	logic            busy_q;
	logic [CNTW-1:0] cnt_q;
	logic [DW-1:0]   rem_q;
	logic [DW-1:0]   den_q;
	logic [NW-1:0]   nq_q;
	logic [DW:0]     rem_sh;
	logic [DW:0]     diff;
	logic            ge;

	always_comb begin
		rem_sh = {rem_q, nq_q[NW-1]};
		diff   = rem_sh - {1'b0, den_q};
		ge     = !diff[DW];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNTW'(NW);
		end else if (busy_q) begin
			busy_q <= (cnt_q != CNTW'(1));
			cnt_q  <= cnt_q - CNTW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			den_q <= den;
			nq_q  <= num;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DW-1:0] : rem_sh[DW-1:0];
			nq_q  <= {nq_q[NW-2:0], ge};
		end
	end

	assign busy = busy_q;
	assign quo  = nq_q;

endmodule

>>> design/ray_unit_cube_face_hit.sv
// ----------------------------------------------------------------------------
// ray_unit_cube_face_hit
// Ray against the unit cube at pos: hit flag and the side struck first.
// ----------------------------------------------------------------------------
// s_* takes one word per ray: cube corner, ray origin and direction, all
// signed fixed point with FRAC_BITS fraction bits. m_* gives one word per
// ray: was_hit and side (side 0 when nothing is hit).
// The twelve cube triangles are tested in turn on one multiply-accumulate
// unit (two passes per product) and one radix-2 divider under a sequencer.
// Per triangle: a setup state, and when det is zero that state alone; else
// the multiply steps for u and v, sign fix and bound test, and for a hit
// that passes the bounds the divide and a ranking state. The next ray is
// taken in the cycle after its result is loaded; s_tready is high only
// while no ray is in work.
// A finished result sits in the output register until m_tready takes it; a
// new ray is accepted meanwhile, and its result waits for that register.
// arst_n clears the sequencer and the output valid at once.
// ----------------------------------------------------------------------------
module ray_unit_cube_face_hit #(
	parameter int FRAC_BITS = rucfh_pkg::FRAC_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// pos_x, pos_y, pos_z, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z
	input  logic [8*rucfh_pkg::IN_BYTES-1:0]    s_tdata,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// was_hit, side, zero fill
	output logic [8*rucfh_pkg::OUT_BYTES-1:0]   m_tdata
);

	localparam int CW   = rucfh_pkg::CW;
	localparam int NW   = rucfh_pkg::TNW - 1 + FRAC_BITS;
	localparam int ACCW = rucfh_pkg::ACCW;
	localparam int MW   = rucfh_pkg::MOPW;
	localparam int DW   = rucfh_pkg::DETW;
	localparam int TW   = rucfh_pkg::TNW;

	rucfh_pkg::state_t state_q, state_d;

	logic [2:0][CW-1:0] pos_q, org_q, dir_q;
	logic [rucfh_pkg::FW-1:0]    face_q;
	logic [rucfh_pkg::STEPW-1:0] step_q;
	rucfh_pkg::geom_t   geo, g_q;
	logic signed [ACCW-1:0] acc, u_q, un_q, vn_q;
	logic [DW-1:0]          det_abs_q;
	logic signed [TW-1:0]   tnum_q;
	logic                   found_q;
	logic [NW-1:0]          best_q;
	logic [rucfh_pkg::FW-1:0] bface_q;
	logic                   mvalid_q, hit_q;
	logic [rucfh_pkg::SIDEW-1:0] side_q;

	rucfh_pkg::mac_ctl_t    mctl;
	logic signed [MW-1:0]   ma, mb;
	logic [1:0]             term;
	logic                   div_start, div_busy;
	logic [NW-1:0]          quo;
	logic                   accept, last_face, reject, better, out_load;
	logic signed [ACCW-1:0] lim;

	rucfh_geom #(.FRAC_BITS(FRAC_BITS)) u_geom (
		.face(face_q), .pos(pos_q), .org(org_q), .dir(dir_q), .g(geo)
	);

	rucfh_mac u_mac (
		.clk(clk), .arst_n(arst_n), .ctl(mctl), .a(ma), .b(mb), .acc(acc)
	);

	rucfh_div #(.NW(NW)) u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.num(NW'(tnum_q[TW-2:0]) << FRAC_BITS), .den(det_abs_q),
		.busy(div_busy), .quo(quo)
	);

	always_comb begin
		accept    = s_tvalid && s_tready;
		last_face = (face_q == rucfh_pkg::LAST_FACE);
		lim       = $signed(ACCW'(det_abs_q) << FRAC_BITS);
		reject    = (tnum_q <= 0) || un_q[ACCW-1] || (un_q > lim) || vn_q[ACCW-1]
			|| ((un_q + vn_q) > lim);
		better    = !found_q || (quo < best_q);
		out_load  = (state_q == rucfh_pkg::ST_DONE) && (!mvalid_q || m_tready);
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			rucfh_pkg::ST_IDLE: begin
				if (s_tvalid) state_d = rucfh_pkg::ST_SETUP;
			end
			rucfh_pkg::ST_SETUP: begin
				if (geo.det != 0) begin
					state_d = rucfh_pkg::ST_MUL;
				end else if (last_face) begin
					state_d = rucfh_pkg::ST_DONE;
				end
			end
			rucfh_pkg::ST_MUL: begin
				if (step_q == rucfh_pkg::STEP_END) state_d = rucfh_pkg::ST_FIX;
			end
			rucfh_pkg::ST_FIX: state_d = rucfh_pkg::ST_TEST;
			rucfh_pkg::ST_TEST: begin
				if (!reject) begin
					state_d = rucfh_pkg::ST_DIV;
				end else begin
					state_d = last_face ? rucfh_pkg::ST_DONE : rucfh_pkg::ST_SETUP;
				end
			end
			rucfh_pkg::ST_DIV: begin
				if (!div_busy) state_d = rucfh_pkg::ST_RANK;
			end
			rucfh_pkg::ST_RANK: begin
				state_d = last_face ? rucfh_pkg::ST_DONE : rucfh_pkg::ST_SETUP;
			end
			rucfh_pkg::ST_DONE: begin
				if (!mvalid_q || m_tready) state_d = rucfh_pkg::ST_IDLE;
			end
			default: state_d = rucfh_pkg::ST_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		s_tready  = (state_q == rucfh_pkg::ST_IDLE);
		div_start = (state_q == rucfh_pkg::ST_TEST) && !reject;
		mctl.en   = (state_q == rucfh_pkg::ST_MUL) && (step_q < rucfh_pkg::STEP_MULS);
		mctl.clr  = (step_q == '0) || (step_q == rucfh_pkg::STEP_V0);
		mctl.hi   = step_q[0];
		term      = (step_q < rucfh_pkg::STEP_V0) ? step_q[2:1]
			: 2'((step_q - rucfh_pkg::STEP_V0) >> 1);
		if (step_q < rucfh_pkg::STEP_V0) begin
			ma = MW'($signed(g_q.tv[term]));
			mb = MW'($signed(g_q.p[term]));
		end else begin
			ma = MW'($signed(dir_q[term]));
			mb = MW'($signed(g_q.q[term]));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= rucfh_pkg::ST_IDLE;
			face_q   <= '0;
			step_q   <= '0;
			found_q  <= 1'b0;
			mvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				face_q  <= '0;
				found_q <= 1'b0;
			end else if ((state_q == rucfh_pkg::ST_SETUP && state_d != rucfh_pkg::ST_MUL)
				|| (state_q == rucfh_pkg::ST_TEST && reject)
				|| state_q == rucfh_pkg::ST_RANK) begin
				if (!last_face) face_q <= face_q + 1'b1;
			end
			if (state_q == rucfh_pkg::ST_RANK && better) found_q <= 1'b1;
			step_q <= (state_q == rucfh_pkg::ST_MUL) ? step_q + 1'b1 : '0;
			if (out_load) begin
				mvalid_q <= 1'b1;
			end else if (m_tready) begin
				mvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			for (int k = 0; k < 3; k++) begin
				pos_q[k] <= s_tdata[k*CW +: CW];
				org_q[k] <= s_tdata[(3+k)*CW +: CW];
				dir_q[k] <= s_tdata[(6+k)*CW +: CW];
			end
		end
		if (state_q == rucfh_pkg::ST_SETUP) g_q <= geo;
		if (state_q == rucfh_pkg::ST_MUL && step_q == rucfh_pkg::STEP_U) u_q <= acc;
		if (state_q == rucfh_pkg::ST_FIX) begin
			det_abs_q <= g_q.det[DW-1] ? DW'(-g_q.det) : DW'(g_q.det);
			tnum_q    <= g_q.det[DW-1] ? -g_q.tnum : g_q.tnum;
			un_q      <= g_q.det[DW-1] ? -u_q : u_q;
			vn_q      <= g_q.det[DW-1] ? -acc : acc;
		end
		if (state_q == rucfh_pkg::ST_RANK && better) begin
			best_q  <= quo;
			bface_q <= face_q;
		end
		if (out_load) begin
			hit_q  <= found_q;
			side_q <= found_q ? bface_q[rucfh_pkg::SIDEW:1] : '0;
		end
	end

	assign m_tvalid = mvalid_q;
	assign m_tdata  = {{(8*rucfh_pkg::OUT_BYTES - 1 - rucfh_pkg::SIDEW){1'b0}}, side_q, hit_q};

endmodule
